[hdl/ttce_pkg.sv]
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and codes of the terminal cursor engine: request payloads,
// request codes, control character codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ttce_pkg;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [2:0] TAB_STEP = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [5:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic [5:0] out_cursor_col;
		logic [4:0] out_cursor_row;
		logic [7:0] out_view_row;
		logic       scrolled;
		logic [7:0] read_data;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_BASE,
		ST_WRITE,
		ST_READ,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic calc_base;
		logic write_cell;
		logic read_cell;
		logic clear_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] in_req;
		logic       in_cr;
		logic       in_rd_ok;
		logic       req_is_read;
		logic       is_tab;
		logic       tab_last;
		logic       clr_last;
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/ttce_ctrl.sv]
// ----------------------------------------------------------------------------
// ttce_ctrl
// Controller state machine: request handshake, sequencing of the address,
// write, read and clear steps, and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire ttce_pkg::dp_status_t status,
	output ttce_pkg::ctrl_cmd_t       cmd
);
	import ttce_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (status.in_req)
						REQ_PUT:   state_d = status.in_cr ? ST_DONE : ST_BASE;
						REQ_READ:  state_d = status.in_rd_ok ? ST_BASE : ST_DONE;
						REQ_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_BASE: begin
				cmd.calc_base = 1'b1;
				state_d       = status.req_is_read ? ST_READ : ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write_cell = 1'b1;
				state_d        = (status.is_tab && !status.tab_last) ? ST_BASE : ST_DONE;
			end
			ST_READ: begin
				cmd.read_cell = 1'b1;
				state_d       = ST_DONE;
			end
			ST_INIT: begin
				cmd.clear_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// A pending result is never overwritten by the next one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result was pending");

	// Every accepted request moves the controller out of the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted request did not start work");

	// A clear request ends with a result, not a silent return to idle.
	a_clear_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && status.clr_last) |=> (state_q == ST_DONE))
		else $error("clear sweep did not produce a result");

endmodule

`default_nettype wire

[hdl/ttce_datapath.sv]
// ----------------------------------------------------------------------------
// ttce_datapath
// Cursor, window and request registers, the cell store with its address
// arithmetic and clear counter, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_datapath #(
	parameter int COLS  = 64,
	parameter int ROWS  = 32,
	parameter int PAGES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ttce_pkg::in_item_t   in_data,
	input  wire ttce_pkg::ctrl_cmd_t  cmd,
	output ttce_pkg::dp_status_t      status,
	output ttce_pkg::out_item_t       out_data
);
	import ttce_pkg::*;

	localparam int STORE_SIZE = ROWS * COLS * PAGES;
	localparam int VIEW_MAX   = (PAGES - 1) * ROWS;
	localparam int CW         = $clog2(COLS);
	localparam int RW         = $clog2(ROWS);
	localparam int VW         = (VIEW_MAX > 0) ? $clog2(VIEW_MAX + 1) : 1;
	localparam int SRW        = $clog2(ROWS * PAGES);
	localparam int AW         = $clog2(STORE_SIZE);

	logic [7:0]    cell_mem_q [STORE_SIZE];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [VW-1:0] view_q;
	logic [AW-1:0] clr_addr_q;
	logic          moved_q;
	logic [1:0]    req_q;
	logic [7:0]    char_q;
	logic [RW-1:0] rd_row_q;
	logic [CW-1:0] rd_col_q;
	logic          rd_ok_q;
	logic [2:0]    tab_cnt_q;
	logic [AW-1:0] base_q;
	logic [7:0]    rd_byte_q;
	out_item_t     out_q;

	logic          can_scroll;
	logic          col_last;
	logic          row_last;
	logic          is_nl;
	logic          is_bs;
	logic          is_tab;
	logic          in_rd_ok;
	logic [RW-1:0] row_sel;
	logic [CW-1:0] col_sel;
	logic [SRW-1:0] store_row;
	logic [AW-1:0] cell_addr;
	logic [7:0]    wr_byte;
	logic          clr_last;

	assign can_scroll = 32'(view_q) < VIEW_MAX;
	assign col_last   = 32'(col_q) == (COLS - 1);
	assign row_last   = 32'(row_q) == (ROWS - 1);
	assign is_nl      = char_q == CH_NL;
	assign is_bs      = char_q == CH_BS;
	assign is_tab     = char_q == CH_TAB;
	assign clr_last   = 32'(clr_addr_q) == (STORE_SIZE - 1);
	assign in_rd_ok   = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);

	assign row_sel    = (req_q == REQ_READ) ? rd_row_q : row_q;
	assign col_sel    = (req_q == REQ_READ) ? rd_col_q : col_q;
	assign store_row  = SRW'(view_q) + SRW'(row_sel);
	assign cell_addr  = base_q + AW'(col_sel);

	always_comb begin
		if (is_tab) begin
			wr_byte = CH_SPACE;
		end else if (is_bs) begin
			wr_byte = '0;
		end else begin
			wr_byte = char_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			view_q     <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
			end
			if (cmd.latch) begin
				if (in_data.req_type == REQ_CLEAR) begin
					col_q  <= '0;
					row_q  <= '0;
					view_q <= '0;
				end else if (in_data.req_type == REQ_PUT && in_data.char_code == CH_BS) begin
					if (col_q != '0) begin
						col_q <= col_q - 1'b1;
					end else if (row_q != '0) begin
						col_q <= CW'(COLS - 1);
						row_q <= row_q - 1'b1;
					end
				end
			end else if (cmd.write_cell) begin
				if (is_nl) begin
					if (can_scroll) begin
						col_q <= '0;
						if (!row_last) begin
							row_q <= row_q + 1'b1;
						end else begin
							view_q <= view_q + 1'b1;
						end
					end
				end else if (!is_bs) begin
					if (!col_last) begin
						col_q <= col_q + 1'b1;
					end else begin
						col_q <= '0;
						if (!row_last) begin
							row_q <= row_q + 1'b1;
						end else if (can_scroll) begin
							view_q <= view_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q     <= in_data.req_type;
			char_q    <= in_data.char_code;
			rd_row_q  <= RW'(in_data.read_row);
			rd_col_q  <= CW'(in_data.read_col);
			rd_ok_q   <= in_rd_ok;
			moved_q   <= in_data.req_type == REQ_CLEAR;
			tab_cnt_q <= TAB_STEP - {1'b0, col_q[1:0]};
		end else if (cmd.write_cell) begin
			if (is_tab) begin
				tab_cnt_q <= tab_cnt_q - 1'b1;
			end
			if (is_nl) begin
				if (can_scroll && row_last) begin
					moved_q <= 1'b1;
				end
			end else if (!is_bs && col_last && row_last && can_scroll) begin
				moved_q <= 1'b1;
			end
		end
		if (cmd.calc_base) begin
			base_q <= AW'(32'(store_row) * COLS);
		end
		if (cmd.load_out) begin
			out_q.out_cursor_col <= 6'(col_q);
			out_q.out_cursor_row <= 5'(row_q);
			out_q.out_view_row   <= 8'(view_q);
			out_q.scrolled       <= moved_q;
			out_q.read_data      <= (req_q == REQ_READ && rd_ok_q) ? rd_byte_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			cell_mem_q[clr_addr_q] <= '0;
		end else if (cmd.write_cell) begin
			cell_mem_q[cell_addr] <= wr_byte;
		end
		if (cmd.read_cell) begin
			rd_byte_q <= cell_mem_q[cell_addr];
		end
	end

	always_comb begin
		status             = '0;
		status.in_req      = in_data.req_type;
		status.in_cr       = in_data.char_code == CH_CR;
		status.in_rd_ok    = in_rd_ok;
		status.req_is_read = req_q == REQ_READ;
		status.is_tab      = is_tab;
		status.tab_last    = tab_cnt_q == 3'd1;
		status.clr_last    = clr_last;
	end

	assign out_data = out_q;

	// The cursor and the window never leave the store.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLS) && (32'(row_q) < ROWS) && (32'(view_q) <= VIEW_MAX))
		else $error("cursor or window out of range");

	// A tab writes between one and four cells.
	a_tab_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write_cell && is_tab) |-> (tab_cnt_q != 3'd0 && tab_cnt_q <= TAB_STEP))
		else $error("tab cell count out of range");

endmodule

`default_nettype wire

[hdl/text_terminal_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Character-cell terminal with a scrollback store: cursor, window top and
// a store of ROWS*COLS*PAGES bytes, driven one request at a time.
//
// Requests enter on in_valid/in_ready and each gives exactly one result on
// out_valid/out_ready, in order. A put or an accepted read steps through
// latch, row address multiply, store access and result load. A tab repeats
// the multiply and store write once per space written, up to four spaces.
// A read outside the window, a carriage return and an unused request type
// go straight from latch to result load. A clear sweeps the store one byte
// per cycle, as the store has a single write port, before its result load.
// After reset the same sweep runs over the whole store with in_ready
// low, and the block comes up with the cursor and window at zero.
// The result register decouples the sides: while a result waits for
// out_ready, the next request is accepted and worked on, and only its
// result load waits for the register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_engine #(
	parameter int COLS  = 64,
	parameter int ROWS  = 32,
	parameter int PAGES = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ttce_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output ttce_pkg::out_item_t      out_data
);
	import ttce_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ttce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ttce_datapath #(
		.COLS  (COLS),
		.ROWS  (ROWS),
		.PAGES (PAGES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
